// ===== hw/rtl/pkl_pkg.sv =====
package pkl_pkg;

  // request codes
  localparam logic [2:0] REQ_INSERT      = 3'd0;
  localparam logic [2:0] REQ_APPEND      = 3'd1;
  localparam logic [2:0] REQ_REMOVE      = 3'd2;
  localparam logic [2:0] REQ_REMOVE_LAST = 3'd3;
  localparam logic [2:0] REQ_READ        = 3'd4;
  localparam logic [2:0] REQ_FIND        = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_KEY,
    S_DN,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/pkl_req_if.sv =====
interface pkl_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [6:0]         position;
  logic signed [31:0] key_in;

  modport source (output valid, req_type, position, key_in, input ready);
  modport sink   (input valid, req_type, position, key_in, output ready);
endinterface

// ===== hw/rtl/pkl_rsp_if.sv =====
interface pkl_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] key_out;
  logic [5:0]         found_position;
  logic [6:0]         entry_count;

  modport source (output valid, status, key_out, found_position, entry_count, input ready);
  modport sink   (input valid, status, key_out, found_position, entry_count, output ready);
endinterface

// ===== hw/rtl/positional_key_list.sv =====
// channel  dir  fields
// req      in   req_type, position, key_in
// rsp      out  status, key_out, found_position, entry_count
//
// one request at a time; req.ready is high only while the sequencer is idle
// refusals go straight to emit; append and insert at the end write in idle; read
// waits on the key ram read; remove shifts the entries behind the position down;
// insert shifts the entries from the position up; find scans from slot 0 to a hit
// reset clears the count and control only; the key ram needs no clearing
// a result waits in the output register while rsp.ready is low
module positional_key_list #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  pkl_req_if.sink   req,
  pkl_rsp_if.source rsp
);
  import pkl_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int EW = (KEY_BITS > 32) ? KEY_BITS : 32;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] p, p_next;
  logic [2:0] op, op_next;
  logic [KEY_BITS-1:0] key_q, key_q_next;
  logic [2:0] res_status, res_status_next;
  logic [KEY_BITS-1:0] res_key, res_key_next;
  logic [IW-1:0] res_pos, res_pos_next;

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic we, re;
  logic [IW-1:0] waddr, raddr;
  logic [KEY_BITS-1:0] wdata, rdata;

  logic load;
  logic out_valid;
  logic [2:0] out_status;
  logic signed [31:0] out_key;
  logic [5:0] out_fpos;
  logic [6:0] out_count;

  logic signed [EW-1:0] key_ext;
  logic signed [EW-1:0] res_key_ext;
  logic [KEY_BITS-1:0] key_w;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic full, empty;

  assign key_ext     = EW'(req.key_in);
  assign key_w       = key_ext[KEY_BITS-1:0];
  assign res_key_ext = EW'(signed'(res_key));
  assign pos_ext     = PW'(req.position);
  assign cnt_ext     = PW'(count);
  assign full        = (count == CW'(CAPACITY));
  assign empty       = (count == '0);

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx        <= idx_next;
    p          <= p_next;
    op         <= op_next;
    key_q      <= key_q_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_pos    <= res_pos_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    p_next          = p;
    op_next         = op;
    key_q_next      = key_q;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_pos_next    = res_pos;
    we              = 1'b0;
    waddr           = idx;
    wdata           = rdata;
    re              = 1'b0;
    raddr           = idx;
    load            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_status_next = ST_OK;
          res_key_next    = '0;
          res_pos_next    = '0;
          key_q_next      = key_w;
          op_next         = req.req_type;
          p_next          = IW'(req.position);
          state_next      = S_EMIT;
          unique case (req.req_type)
            REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                res_status_next = ST_RANGE;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else if (pos_ext == cnt_ext) begin
                we         = 1'b1;
                waddr      = count[IW-1:0];
                wdata      = key_w;
                count_next = count + CW'(1);
              end else begin
                re         = 1'b1;
                raddr      = IW'(count - CW'(1));
                idx_next   = IW'(count - CW'(1));
                state_next = S_UP;
              end
            end
            REQ_APPEND: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[IW-1:0];
                wdata      = key_w;
                count_next = count + CW'(1);
              end
            end
            REQ_REMOVE, REQ_READ: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status_next = ST_RANGE;
              end else begin
                re         = 1'b1;
                raddr      = IW'(req.position);
                state_next = S_KEY;
              end
            end
            REQ_REMOVE_LAST: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                p_next     = IW'(count - CW'(1));
                re         = 1'b1;
                raddr      = IW'(count - CW'(1));
                state_next = S_KEY;
              end
            end
            REQ_FIND: begin
              if (empty) begin
                res_status_next = ST_MISSING;
              end else begin
                re         = 1'b1;
                raddr      = '0;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // move one key up a slot per cycle, from the back toward the position
      S_UP: begin
        we    = 1'b1;
        waddr = idx + IW'(1);
        wdata = rdata;
        if (idx == p) begin
          state_next = S_PUT;
        end else begin
          re       = 1'b1;
          raddr    = idx - IW'(1);
          idx_next = idx - IW'(1);
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = p;
        wdata      = key_q;
        count_next = count + CW'(1);
        state_next = S_EMIT;
      end
      S_KEY: begin
        res_key_next = rdata;
        if (op == REQ_READ) begin
          state_next = S_EMIT;
        end else if (CW'(p) + CW'(1) < count) begin
          re         = 1'b1;
          raddr      = p + IW'(1);
          idx_next   = p + IW'(1);
          state_next = S_DN;
        end else begin
          count_next = count - CW'(1);
          state_next = S_EMIT;
        end
      end
      // close the gap: one key down a slot per cycle
      S_DN: begin
        we    = 1'b1;
        waddr = idx - IW'(1);
        wdata = rdata;
        if (CW'(idx) + CW'(1) < count) begin
          re       = 1'b1;
          raddr    = idx + IW'(1);
          idx_next = idx + IW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (rdata == key_q) begin
          res_pos_next = idx;
          state_next   = S_EMIT;
        end else if (CW'(idx) + CW'(1) < count) begin
          re       = 1'b1;
          raddr    = idx + IW'(1);
          idx_next = idx + IW'(1);
        end else begin
          res_status_next = ST_MISSING;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_status <= res_status;
      out_key    <= res_key_ext[31:0];
      out_fpos   <= 6'(res_pos);
      out_count  <= 7'(count);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.key_out        = out_key;
  assign rsp.found_position = out_fpos;
  assign rsp.entry_count    = out_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> (count == $past(count) + CW'(1)) ||
                        (count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP) |-> (CW'(idx) < count) && (idx >= p))
    else $error("shift index outside the held keys");

  a_two_cycles: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted on back-to-back cycles");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_MISSING) |->
      (rsp.found_position == '0) && (rsp.key_out == '0))
    else $error("miss result carries a key or a position");

endmodule
